// File: sv/btne_pkg.sv
// ----------------------------------------------------------------------------
// btne_pkg: shared types for the binary threshold network evaluator
// Beat payloads, command codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package btne_pkg;

  localparam int WEIGHT_W = 12;
  localparam int SENSOR_W = 8;
  localparam int OUT_BITS_W = 8;

  // Widest index fields over the supported parameter range
  localparam int MAX_NW = 5;
  localparam int MAX_LW = 3;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t                   command;
    logic                        weight_layer;
    logic [2:0]                  weight_row;
    logic [2:0]                  weight_col;
    logic signed [WEIGHT_W-1:0]  weight_value;
    logic [SENSOR_W-1:0]         sensor_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [OUT_BITS_W-1:0] output_bits;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;     // store the weight of the accepted load beat
    logic              start;     // latch sensor bits, evaluation begins
    logic              rd_en;     // fetch one weight
    logic              first;     // fetch is the first term of a neuron's sum
    logic              last_col;  // fetch is the last term of a neuron's sum
    logic              last_row;  // fetch belongs to the last row of the layer
    logic [MAX_LW-1:0] lay;
    logic [MAX_NW-1:0] row;
    logic [MAX_NW-1:0] col;
    logic              out_load;  // move the last layer into the output register
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: sv/binary_threshold_network_eval.sv
// ----------------------------------------------------------------------------
// binary_threshold_network_eval: feed-forward binary threshold network
// Top level: sequencer plus weight-store datapath.
// ----------------------------------------------------------------------------
// A load beat (command 0) writes one signed weight into the store and the
// block stays ready for a new beat. An evaluate beat (command 1) places the
// sensor bits on the first layer and computes every later layer with one
// shared accumulator that adds one weight per cycle from the single-port
// weight store, so it keeps the input stalled while it fetches every weight,
// sums the last one and moves the result on, and then one result beat
// appears in the output register; if that register still holds an earlier
// result that is being stalled, the new result and the input stall wait
// until the earlier beat has been taken.
// Weights must be loaded before they are used; unloaded entries read back
// unknown values.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_threshold_network_eval #(
  parameter int NEURONS_PER_LAYER = 8,
  parameter int LAYER_COUNT       = 3,
  parameter int WEIGHT_FRAC_BITS  = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire btne_pkg::in_item_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      btne_pkg::out_item_t out_data
);

  btne_pkg::dp_cmd_t dp_cmd;

  btne_ctrl #(
    .NEURONS (NEURONS_PER_LAYER),
    .LAYERS  (LAYER_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_data.command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  btne_dp #(
    .NEURONS   (NEURONS_PER_LAYER),
    .LAYERS    (LAYER_COUNT),
    .FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .dp_cmd   (dp_cmd),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: sv/btne_ctrl.sv
// ----------------------------------------------------------------------------
// btne_ctrl: evaluation sequencer
// Accepts beats, walks layer/row/column over the weight store and hands the
// result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module btne_ctrl #(
  parameter int NEURONS = 8,
  parameter int LAYERS  = 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire btne_pkg::cmd_code_t in_cmd,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      btne_pkg::dp_cmd_t   dp_cmd
);

  localparam int NW  = $clog2(NEURONS);
  localparam int LW  = (LAYERS > 2) ? $clog2(LAYERS - 1) : 1;
  localparam int PNW = btne_pkg::MAX_NW;
  localparam int PLW = btne_pkg::MAX_LW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t          state_r, state_nxt;
  logic [NW-1:0]   row_r, row_nxt;
  logic [NW-1:0]   col_r, col_nxt;
  logic [LW-1:0]   lay_r, lay_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic accept;
  logic col_end, row_end, lay_end;
  logic out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign col_end = (col_r == NW'(NEURONS - 1));
  assign row_end = (row_r == NW'(NEURONS - 1));
  assign lay_end = (lay_r == LW'(LAYERS - 2));

  always_comb begin
    dp_cmd          = '0;
    dp_cmd.wr_en    = accept && (in_cmd == btne_pkg::CMD_LOAD);
    dp_cmd.start    = accept && (in_cmd == btne_pkg::CMD_EVAL);
    dp_cmd.rd_en    = (state_r == S_RUN);
    dp_cmd.first    = (col_r == '0);
    dp_cmd.last_col = col_end;
    dp_cmd.last_row = row_end;
    dp_cmd.lay      = PLW'(lay_r);
    dp_cmd.row      = PNW'(row_r);
    dp_cmd.col      = PNW'(col_r);
    dp_cmd.out_load = (state_r == S_FIN) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    lay_nxt       = lay_r;
    out_valid_nxt = out_valid_r;

    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (dp_cmd.start) begin
          state_nxt = S_RUN;
          row_nxt   = '0;
          col_nxt   = '0;
          lay_nxt   = '0;
        end
      end
      S_RUN: begin
        if (col_end) begin
          col_nxt = '0;
          if (row_end) begin
            row_nxt = '0;
            if (lay_end) begin
              state_nxt = S_DRAIN;
            end else begin
              lay_nxt = lay_r + 1'b1;
            end
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      // last fetched weight is being summed
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      lay_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      lay_r       <= lay_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/btne_dp.sv
// ----------------------------------------------------------------------------
// btne_dp: weight store, shared accumulator and activation registers
// One weight is read and added per cycle; the threshold is tested on the
// full sum of each neuron.
// ----------------------------------------------------------------------------
`default_nettype none

module btne_dp #(
  parameter int NEURONS   = 8,
  parameter int LAYERS    = 3,
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire btne_pkg::in_item_t in_data,
  input  wire btne_pkg::dp_cmd_t  dp_cmd,
  output      btne_pkg::out_item_t out_data
);

  localparam int WW     = btne_pkg::WEIGHT_W;
  localparam int NW     = $clog2(NEURONS);
  localparam int LW     = (LAYERS > 2) ? $clog2(LAYERS - 1) : 1;
  localparam int DEPTH  = (LAYERS - 1) * NEURONS * NEURONS;
  localparam int AW     = $clog2(DEPTH);
  localparam int AEXT   = AW + 4;
  localparam int GROW_W = WW + $clog2(NEURONS) + 1;
  localparam int SUM_W  = (GROW_W > FRAC_BITS + 1) ? GROW_W : FRAC_BITS + 1;
  localparam logic signed [SUM_W-1:0] THRESH = SUM_W'(1 << (FRAC_BITS - 1));

  logic [WW-1:0] mem [DEPTH];

  logic signed [WW-1:0]    rd_data_r;
  logic                    stg_vld_r;
  btne_pkg::dp_cmd_t       stg_r;
  logic signed [SUM_W-1:0] acc_r;
  logic [NEURONS-1:0]      act_cur_r;
  logic [NEURONS-1:0]      act_nxt_r;
  btne_pkg::out_item_t     out_data_r;

  logic                    wr_in_range;
  logic [AEXT-1:0]         wr_addr_ext;
  logic [AEXT-1:0]         rd_addr_ext;
  logic [NEURONS-1:0]      sensor_vec;
  logic [btne_pkg::OUT_BITS_W-1:0] last_bits;
  logic signed [SUM_W-1:0] w_ext;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] acc_sum;
  logic                    src_bit;
  logic                    fire;
  logic [NEURONS-1:0]      act_new;

  // ---- weight store ----
  assign wr_in_range = (int'(in_data.weight_layer) < LAYERS - 1) &&
                       (int'(in_data.weight_row) < NEURONS) &&
                       (int'(in_data.weight_col) < NEURONS);

  assign wr_addr_ext = AEXT'(in_data.weight_layer) * AEXT'(NEURONS * NEURONS) +
                       AEXT'(in_data.weight_row) * AEXT'(NEURONS) +
                       AEXT'(in_data.weight_col);

  assign rd_addr_ext = AEXT'(dp_cmd.lay[LW-1:0]) * AEXT'(NEURONS * NEURONS) +
                       AEXT'(dp_cmd.row[NW-1:0]) * AEXT'(NEURONS) +
                       AEXT'(dp_cmd.col[NW-1:0]);

  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en && wr_in_range) begin
      mem[wr_addr_ext[AW-1:0]] <= in_data.weight_value;
    end
    if (dp_cmd.rd_en) begin
      rd_data_r <= mem[rd_addr_ext[AW-1:0]];
    end
  end

  // ---- input layer and result bit mapping ----
  for (genvar g = 0; g < NEURONS; g++) begin : g_sensor
    if (g < btne_pkg::SENSOR_W) begin : g_used
      assign sensor_vec[g] = in_data.sensor_bits[g];
    end else begin : g_zero
      assign sensor_vec[g] = 1'b0;
    end
  end

  for (genvar g = 0; g < btne_pkg::OUT_BITS_W; g++) begin : g_out
    if (g < NEURONS) begin : g_used
      assign last_bits[g] = act_cur_r[g];
    end else begin : g_zero
      assign last_bits[g] = 1'b0;
    end
  end

  // ---- accumulate stage, aligned with the read data ----
  assign w_ext   = SUM_W'(rd_data_r);
  assign src_bit = act_cur_r[stg_r.col[NW-1:0]];
  assign term    = src_bit ? w_ext : '0;
  assign acc_sum = (stg_r.first ? '0 : acc_r) + term;
  assign fire    = (acc_sum >= THRESH);

  always_comb begin
    act_new = act_nxt_r;
    act_new[stg_r.row[NW-1:0]] = fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      act_cur_r <= '0;
      act_nxt_r <= '0;
    end else begin
      stg_vld_r <= dp_cmd.rd_en;
      if (dp_cmd.start) begin
        act_cur_r <= sensor_vec;
      end else if (stg_vld_r && stg_r.last_col) begin
        act_nxt_r <= act_new;
        // layer finished: it feeds the next one
        if (stg_r.last_row) begin
          act_cur_r <= act_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= dp_cmd;
    if (stg_vld_r) begin
      acc_r <= acc_sum;
    end
    if (dp_cmd.out_load) begin
      out_data_r.action      <= {act_cur_r[0], act_cur_r[1]};
      out_data_r.output_bits <= last_bits;
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

// File: sv/btne_checker.sv
// ----------------------------------------------------------------------------
// btne_checker: port-level checks for the network evaluator
// Handshake rules on the result side and load/evaluate sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module btne_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire btne_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire btne_pkg::out_item_t out_data
);

  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result beat changed");

  // a load never leaves the block busy
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.command == btne_pkg::CMD_LOAD) |=> !in_stall)
    else $error("busy after load beat");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.command == btne_pkg::CMD_EVAL) |=> in_stall)
    else $error("not busy after evaluate beat");

  // a new result only appears at the end of an evaluation
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without evaluation");

endmodule

bind binary_threshold_network_eval btne_checker u_btne_checker (.*);

`default_nettype wire
